// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: sv/hss_pkg.sv
`default_nettype none

package hss_pkg;

  localparam int SET_W  = 6;
  localparam int CNT_W  = 5;
  localparam int CFG_W  = 7;
  localparam int TBL_CAP = 1 << SET_W;

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_WRITE   = 1'b1;

  localparam logic [CFG_W-1:0] SETS_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } hss_state_t;

  typedef struct packed {
    logic write;
    logic load;
    logic scan;
    logic finish;
  } hss_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
  } hss_status_t;

endpackage

`default_nettype wire

// File: sv/hss_ctrl.sv
`default_nettype none

module hss_ctrl
  import hss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        in_command,
  input  wire hss_status_t status,
  output logic             busy,
  output hss_cmd_t         cmd
);

  hss_state_t state_r, state_nxt;
  logic       accept;

  assign accept = start && !busy;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          if (in_command == CMD_WRITE) begin
            cmd.write = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit || status.last) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/hss_datapath.sv
`default_nettype none

module hss_datapath
  import hss_pkg::*;
#(
  parameter int MAX_SETS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hss_cmd_t         cmd,
  output hss_status_t           status,
  input  wire logic [SET_W-1:0] in_target_set,
  input  wire logic [CNT_W-1:0] in_failed_count,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  output logic                  out_valid,
  output logic [SET_W-1:0]      out_chosen_set,
  output logic                  out_needs_recovery
);

  // Sets at or above the set-index range can never be written and always read as healthy.
  localparam int TBL_DEPTH = (MAX_SETS < TBL_CAP) ? MAX_SETS : TBL_CAP;
  localparam int TAW       = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  logic [CNT_W-1:0]     tbl_r [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] vld_r;

  logic [CFG_W-1:0] sets_r;
  logic [SET_W-1:0] cur_r;
  logic [SET_W-1:0] start_r;
  logic [CFG_W-1:0] n_r;
  logic [CFG_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CFG_W-1:0] chk_ptr_r;
  logic [CFG_W-1:0] chk_cnt_r;
  logic             chk_vld_r;
  logic [CNT_W-1:0] rd_data_r;
  logic             rd_vld_r;
  logic             rd_inr_r;

  logic [CFG_W-1:0] n_act;
  logic [SET_W-1:0] start_set;
  logic             healthy;
  logic             wr_ok;
  logic             out_valid_r;
  logic [SET_W-1:0] out_set_r;
  logic             out_nr_r;

  always_comb begin
    if (sets_r == '0) begin
      n_act = CFG_W'(1);
    end else if (32'(sets_r) > MAX_SETS) begin
      n_act = CFG_W'(MAX_SETS);
    end else begin
      n_act = sets_r;
    end
  end

  assign start_set  = (CFG_W'(cur_r) < n_act) ? cur_r : '0;
  assign rd_ptr_nxt = (rd_ptr_r == n_r - CFG_W'(1)) ? '0 : rd_ptr_r + CFG_W'(1);
  assign healthy    = !rd_inr_r || !rd_vld_r || (rd_data_r == '0);
  assign status.hit  = chk_vld_r && healthy;
  assign status.last = chk_vld_r && (chk_cnt_r == n_r - CFG_W'(1));
  assign wr_ok      = cmd.write && (32'(in_target_set) < MAX_SETS);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      tbl_r[in_target_set[TAW-1:0]] <= in_failed_count;
    end
    rd_data_r <= tbl_r[rd_ptr_r[TAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_ok) begin
        vld_r[in_target_set[TAW-1:0]] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_ptr_r[TAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    rd_inr_r  <= (32'(rd_ptr_r) < TBL_DEPTH);
    chk_ptr_r <= rd_ptr_r;
    if (cmd.load) begin
      n_r       <= n_act;
      start_r   <= start_set;
      rd_ptr_r  <= CFG_W'(start_set);
      chk_cnt_r <= '0;
    end else if (cmd.scan) begin
      rd_ptr_r <= rd_ptr_nxt;
      if (chk_vld_r) begin
        chk_cnt_r <= chk_cnt_r + CFG_W'(1);
      end
    end
    if (cmd.finish) begin
      out_set_r <= status.hit ? chk_ptr_r[SET_W-1:0] : start_r;
      out_nr_r  <= !status.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sets_r      <= SETS_RESET;
      cur_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        sets_r <= cfg_wdata;
      end
      chk_vld_r   <= cmd.scan && !cmd.finish;
      out_valid_r <= cmd.finish;
      if (cmd.finish) begin
        cur_r <= status.hit ? chk_ptr_r[SET_W-1:0] : start_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_chosen_set     = out_set_r;
  assign out_needs_recovery = out_nr_r;

endmodule

`default_nettype wire

// File: sv/healthy_set_selector.sv
// Channel        | Ports                                         | Flow
// ---------------+-----------------------------------------------+---------------------
// request in     | start, busy, in_command, in_target_set,       | start with busy low
//                | in_failed_count                               |
// result out     | out_valid, out_chosen_set, out_needs_recovery | one-cycle strobe
// configuration  | cfg_we, cfg_wdata                             | write on cfg_we
//
// A write request is taken while idle and busy stays low.
// A placement request holds busy until the scan ends at a healthy set or after all sets in use:
// the scan reads the failure table one entry per cycle through its single read port.
// The result strobe comes in the cycle in which busy falls; the receiver cannot stall it.
// Reset is synchronous and active low; it clears the table's valid bits at once.
`default_nettype none

module healthy_set_selector
  import hss_pkg::*;
#(
  parameter int MAX_SETS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             in_command,
  input  wire logic [SET_W-1:0] in_target_set,
  input  wire logic [CNT_W-1:0] in_failed_count,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  output logic                  out_valid,
  output logic [SET_W-1:0]      out_chosen_set,
  output logic                  out_needs_recovery
);

  hss_cmd_t    cmd;
  hss_status_t status;

  hss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .status     (status),
    .busy       (busy),
    .cmd        (cmd)
  );

  hss_datapath #(
    .MAX_SETS (MAX_SETS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_target_set      (in_target_set),
    .in_failed_count    (in_failed_count),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_chosen_set     (out_chosen_set),
    .out_needs_recovery (out_needs_recovery)
  );

endmodule

`default_nettype wire

// File: sv/hss_checker.sv
`default_nettype none
`include "assert_macros.svh"

module hss_checker
  import hss_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_command,
  input wire logic out_valid
);

  logic req_acc;
  logic wr_acc;

  assign req_acc = start && !busy && (in_command == CMD_REQUEST);
  assign wr_acc  = start && !busy && (in_command == CMD_WRITE);

  // A placement request occupies the block until its result is produced.
  `ASSERT_CLK_RST(a_req_busy, clk, rst_n, req_acc |=> busy)
  // A write request never occupies the block.
  `ASSERT_CLK_RST(a_wr_free, clk, rst_n, wr_acc |=> !busy && !out_valid)
  // Each result comes at the end of a busy period.
  `ASSERT_CLK_RST(a_res_after_busy, clk, rst_n, out_valid |-> $past(busy) && !busy)
  // Results are never back to back.
  `ASSERT_CLK_RST(a_res_single, clk, rst_n, out_valid |=> !out_valid)
  // Reset leaves the block idle with no result.
  `ASSERT_CLK(a_reset_idle, clk, !rst_n |=> !busy && !out_valid)

endmodule

bind healthy_set_selector hss_checker u_hss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_command (in_command),
  .out_valid  (out_valid)
);

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;
  import hss_pkg::*;

  typedef struct packed {
    logic [SET_W-1:0] chosen;
    logic             recovery;
  } placement_t;

  typedef enum logic {
    ROW_SET_COUNT,
    ROW_REQUEST
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [CFG_W-1:0] sets_val;
    logic             cmd;
    logic [SET_W-1:0] target;
    logic [CNT_W-1:0] count;
    logic             typed;
    logic [SET_W-1:0] exp_set;
    logic             exp_recovery;
  } directed_row_t;

  localparam int NUM_ROWS = 23;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_command = CMD_REQUEST;
  logic [SET_W-1:0] in_target_set = '0;
  logic [CNT_W-1:0] in_failed_count = '0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic busy;
  logic out_valid;
  logic [SET_W-1:0] out_chosen_set;
  logic out_needs_recovery;

  logic row_typed = 1'b0;
  placement_t row_exp = '0;

  logic [CNT_W-1:0] failed_model [TBL_CAP];
  logic [SET_W-1:0] pointer_model = '0;
  logic [CFG_W-1:0] sets_model = SETS_RESET;
  placement_t expected_placements [$];
  int errors = 0;
  int quiet_cycles = 0;
  int idle_pct = 16;

  directed_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_REQUEST,   7'd0,   CMD_REQUEST, 6'd0,  5'd0,  1'b1, 6'd0, 1'b0},
    '{ROW_REQUEST,   7'd0,   CMD_WRITE,   6'd0,  5'd31, 1'b0, 6'd0, 1'b0},
    '{ROW_REQUEST,   7'd0,   CMD_REQUEST, 6'd63, 5'd31, 1'b1, 6'd1, 1'b0},
    '{ROW_REQUEST,   7'd0,   CMD_REQUEST, 6'd0,  5'd0,  1'b1, 6'd1, 1'b0},
    '{ROW_REQUEST,   7'd0,   CMD_WRITE,   6'd63, 5'd1,  1'b0, 6'd0, 1'b0},
    '{ROW_REQUEST,   7'd0,   CMD_WRITE,   6'd1,  5'd1,  1'b0, 6'd0, 1'b0},
    '{ROW_REQUEST,   7'd0,   CMD_REQUEST, 6'd0,  5'd0,  1'b1, 6'd2, 1'b0},
    '{ROW_SET_COUNT, 7'd2,   CMD_REQUEST, 6'd0,  5'd0,  1'b0, 6'd0, 1'b0},
    '{ROW_REQUEST,   7'd0,   CMD_REQUEST, 6'd0,  5'd0,  1'b1, 6'd0, 1'b1},
    '{ROW_SET_COUNT, 7'd0,   CMD_REQUEST, 6'd0,  5'd0,  1'b0, 6'd0, 1'b0},
    '{ROW_REQUEST,   7'd0,   CMD_REQUEST, 6'd0,  5'd0,  1'b1, 6'd0, 1'b1},
    '{ROW_REQUEST,   7'd0,   CMD_WRITE,   6'd0,  5'd0,  1'b0, 6'd0, 1'b0},
    '{ROW_REQUEST,   7'd0,   CMD_REQUEST, 6'd0,  5'd0,  1'b1, 6'd0, 1'b0},
    '{ROW_REQUEST,   7'd0,   CMD_WRITE,   6'd0,  5'd16, 1'b0, 6'd0, 1'b0},
    '{ROW_REQUEST,   7'd0,   CMD_WRITE,   6'd2,  5'd8,  1'b0, 6'd0, 1'b0},
    '{ROW_SET_COUNT, 7'd3,   CMD_REQUEST, 6'd0,  5'd0,  1'b0, 6'd0, 1'b0},
    '{ROW_REQUEST,   7'd0,   CMD_REQUEST, 6'd0,  5'd0,  1'b1, 6'd0, 1'b1},
    '{ROW_SET_COUNT, 7'd127, CMD_REQUEST, 6'd0,  5'd0,  1'b0, 6'd0, 1'b0},
    '{ROW_REQUEST,   7'd0,   CMD_REQUEST, 6'd0,  5'd0,  1'b1, 6'd3, 1'b0},
    '{ROW_REQUEST,   7'd0,   CMD_WRITE,   6'd3,  5'd21, 1'b0, 6'd0, 1'b0},
    '{ROW_REQUEST,   7'd0,   CMD_REQUEST, 6'd42, 5'd10, 1'b0, 6'd0, 1'b0},
    '{ROW_SET_COUNT, 7'd64,  CMD_REQUEST, 6'd0,  5'd0,  1'b0, 6'd0, 1'b0},
    '{ROW_REQUEST,   7'd0,   CMD_REQUEST, 6'd0,  5'd0,  1'b0, 6'd0, 1'b0}
  };

  healthy_set_selector u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_target_set      (in_target_set),
    .in_failed_count    (in_failed_count),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_chosen_set     (out_chosen_set),
    .out_needs_recovery (out_needs_recovery)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < TBL_CAP; i++) failed_model[i] = '0;
  end

  function automatic int active_sets(input logic [CFG_W-1:0] sets_val);
    if (sets_val == 0) return 1;
    if (sets_val > TBL_CAP) return TBL_CAP;
    return int'(sets_val);
  endfunction

  // Walks forward from the pointer to the first set with no failures.
  task automatic place_request(output placement_t placement);
    int n;
    int p;
    bit found;
    n = active_sets(sets_model);
    if (int'(pointer_model) >= n) pointer_model = '0;
    p = int'(pointer_model);
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found) begin
        if (failed_model[p] == 0) found = 1'b1;
        else p = (p + 1) % n;
      end
    end
    if (!found) p = int'(pointer_model);
    pointer_model = SET_W'(p);
    placement.chosen = SET_W'(p);
    placement.recovery = !found;
  endtask

  always @(posedge clk) begin
    placement_t got;
    placement_t want;
    if (rst_n) begin
      if (out_valid) begin
        got = {out_chosen_set, out_needs_recovery};
        if (expected_placements.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual set %0d recovery %0b",
                   $time, got.chosen, got.recovery);
          errors++;
        end else begin
          want = expected_placements.pop_front();
          if (got.chosen != want.chosen) begin
            $display("%0t: chosen_set expected %0d actual %0d", $time, want.chosen, got.chosen);
            errors++;
          end
          if (got.recovery != want.recovery) begin
            $display("%0t: needs_recovery expected %0b actual %0b",
                     $time, want.recovery, got.recovery);
            errors++;
          end
        end
      end
      if (cfg_we) sets_model = cfg_wdata;
      if (start && !busy) begin
        if (in_command == CMD_WRITE) begin
          failed_model[in_target_set] = in_failed_count;
        end else begin
          place_request(want);
          if (row_typed) want = row_exp;
          expected_placements.push_back(want);
        end
      end
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(input logic cmd, input logic [SET_W-1:0] target,
                              input logic [CNT_W-1:0] count, input logic typed,
                              input placement_t exp_placement);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_target_set <= target;
    in_failed_count <= count;
    row_typed <= typed;
    row_exp <= exp_placement;
    do @(posedge clk); while (busy);
  endtask

  // The set count changes only once every pending result has come out.
  task automatic write_sets(input logic [CFG_W-1:0] sets_val);
    start <= 1'b0;
    @(posedge clk);
    while (expected_placements.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= sets_val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] sets_val;
    logic cmd;
    logic [SET_W-1:0] target;
    logic [CNT_W-1:0] count;
    int n_eff;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_SET_COUNT) begin
        write_sets(directed_rows[r].sets_val);
      end else begin
        send_request(directed_rows[r].cmd, directed_rows[r].target, directed_rows[r].count,
                     directed_rows[r].typed,
                     {directed_rows[r].exp_set, directed_rows[r].exp_recovery});
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 16 : (phase == 1) ? 66 : 0;
      for (int seg = 0; seg < 6; seg++) begin
        case ($urandom_range(7))
          0: sets_val = 7'd0;
          1: sets_val = 7'd1;
          2: sets_val = 7'd2;
          3: sets_val = 7'd127;
          4: sets_val = 7'd64;
          5: sets_val = CFG_W'($urandom_range(3, 8));
          6: sets_val = CFG_W'($urandom_range(9, 63));
          default: sets_val = CFG_W'($urandom_range(65, 127));
        endcase
        write_sets(sets_val);
        n_eff = active_sets(sets_val);
        repeat (64) begin
          cmd = ($urandom_range(99) < 45) ? CMD_WRITE : CMD_REQUEST;
          if ($urandom_range(9) < 8) target = SET_W'($urandom_range(n_eff - 1));
          else target = SET_W'($urandom_range(TBL_CAP - 1));
          count = ($urandom_range(2) == 0) ? '0 : CNT_W'($urandom_range(31));
          send_request(cmd, target, count, 1'b0, '0);
        end
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (expected_placements.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
